@@ rtl/skm_pkg.sv @@
// Package for the spike key matcher: sizes, codes and the item and state types.
// Used by every module under rtl; depends on nothing.
package skm_pkg;

    localparam int NumEntries = 4;
    localparam int MaxSpikes  = 64;
    localparam int EntryW     = $clog2(NumEntries);
    localparam int SlotW      = $clog2(MaxSpikes);
    localparam int StoreDepth = NumEntries * MaxSpikes;
    localparam int StoreAw    = $clog2(StoreDepth);

    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_SPIKE = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;
    localparam logic [1:0] KIND_NONE  = 2'd3;   // unassigned kind code

    localparam logic [2:0] ST_STORED   = 3'd0;
    localparam logic [2:0] ST_DELAY    = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_NOMATCH  = 3'd3;
    localparam logic [2:0] ST_TABLE    = 3'd4;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_PROD,
        S_OUT
    } state_t;

    // item travelling down the cell row
    typedef struct packed {
        logic             valid;
        logic [1:0]       kind;
        logic [31:0]      ptime;
        logic [31:0]      pkey;
        logic [1:0]       sel;
        logic [31:0]      mkey;
        logic [31:0]      mmask;
        logic [4:0]       cshift;
        logic [31:0]      cmask;
        logic [4:0]       cbits;
        logic [31:0]      percore;
        logic [6:0]       limit;
        logic [2:0]       nuse;
        logic             done;    // scan already stopped
        logic             lost;
        logic [1:0]       lost_e;
        logic             hit;     // a store or full hit happened
        logic             full;
        logic [1:0]       hit_e;
        logic [30:0]      delay;
        logic [31:0]      core;
        logic [31:0]      local_id;
        logic [31:0]      percore_h;
        logic [SlotW-1:0] slot;
        logic [31:0]      rcv;
        logic [31:0]      dlost;
        logic [31:0]      olost;
        logic [6:0]       cnt;
    } token_t;

endpackage

@@ rtl/skm_cell.sv @@
// One table entry of the matcher row: holds the entry's fields and counters
// and hands the item on to the next cell each cycle that adv is high. Uses skm_pkg.
module skm_cell (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [skm_pkg::EntryW-1:0] cell_id,
    input  logic                  adv,
    input  skm_pkg::token_t       tok_in,
    output skm_pkg::token_t       tok_out
);
    import skm_pkg::*;

    logic [31:0] key_reg, mask_reg, cmask_reg, pc_reg;
    logic [4:0]  shift_reg, cb_reg;
    logic [6:0]  lim_reg, cnt_reg;
    logic [31:0] rcv_reg, dl_reg, ol_reg;
    token_t      tok_reg, tok_next;
    logic [31:0] cmaskc, dly, lmask;
    logic [6:0]  lim_eff;
    logic        act, match, late, isfull;

    always_comb begin
        cmaskc  = (32'd1 << cb_reg) - 32'd1;
        dly     = (tok_in.ptime & cmaskc) - (tok_in.pkey & cmaskc);
        lmask   = ~(mask_reg | (cmask_reg << shift_reg));
        lim_eff = (lim_reg > 7'(MaxSpikes)) ? 7'(MaxSpikes) : lim_reg;
        act     = tok_in.valid && tok_in.kind == KIND_SPIKE && !tok_in.done
                  && ({1'b0, cell_id} < tok_in.nuse);
        match   = act && ((tok_in.pkey & mask_reg) == key_reg);
        late    = dly > cmaskc;
        isfull  = cnt_reg >= lim_eff;
        tok_next = tok_in;
        if (match) begin
            tok_next.rcv   = rcv_reg + 32'd1;
            tok_next.dlost = dl_reg;
            tok_next.olost = ol_reg;
            tok_next.cnt   = cnt_reg;
            if (late) begin
                tok_next.lost   = 1'b1;
                tok_next.lost_e = 2'(cell_id);
                tok_next.dlost  = dl_reg + 32'd1;
            end else begin
                tok_next.done      = 1'b1;
                tok_next.hit       = 1'b1;
                tok_next.full      = isfull;
                tok_next.hit_e     = 2'(cell_id);
                tok_next.delay     = dly[30:0];
                tok_next.core      = (tok_in.pkey >> shift_reg) & cmask_reg;
                tok_next.local_id  = (tok_in.pkey & lmask) >> cb_reg;
                tok_next.percore_h = pc_reg;
                tok_next.slot      = cnt_reg[SlotW-1:0];
                if (isfull) begin
                    tok_next.olost = ol_reg + 32'd1;
                end else begin
                    tok_next.cnt = cnt_reg + 7'd1;
                end
            end
        end else if (tok_in.valid && tok_in.kind == KIND_WRITE
                     && tok_in.sel == 2'(cell_id)) begin
            tok_next.hit_e = 2'(cell_id);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg <= '0; mask_reg <= '0; cmask_reg <= '0; pc_reg <= '0;
            shift_reg <= '0; cb_reg <= '0; lim_reg <= '0; cnt_reg <= '0;
            rcv_reg <= '0; dl_reg <= '0; ol_reg <= '0;
            tok_reg <= '0;
        end else if (adv) begin
            tok_reg <= tok_next;
            if (tok_in.valid && tok_in.kind == KIND_WRITE
                && tok_in.sel == 2'(cell_id)) begin
                key_reg <= tok_in.mkey; mask_reg <= tok_in.mmask;
                cmask_reg <= tok_in.cmask; pc_reg <= tok_in.percore;
                shift_reg <= tok_in.cshift; cb_reg <= tok_in.cbits;
                lim_reg <= tok_in.limit; cnt_reg <= '0;
                rcv_reg <= '0; dl_reg <= '0; ol_reg <= '0;
            end else if (tok_in.valid && tok_in.kind == KIND_CLEAR) begin
                cnt_reg <= '0;
            end else if (match) begin
                rcv_reg <= tok_next.rcv;
                dl_reg  <= tok_next.dlost;
                ol_reg  <= tok_next.olost;
                cnt_reg <= tok_next.cnt;
            end
        end
    end

    // lost-entry reporting needs that entry's final counters; the token carries them on
    assign tok_out = tok_reg;
endmodule

@@ rtl/spike_key_matcher.sv @@
// Spike key matcher: one item passes the row of entry cells one cell a cycle.
// The item passes the row of entry cells, then the capture registers (fin_reg,
// st_reg), then the multiply register (prod_reg) before m_tvalid rises. One item
// at a time: a new item is taken only once the last result has been accepted.
// Synchronous active-low reset clears table, counters, control; no clearing
// pass (the spike list memory is write-only). Uses skm_pkg and skm_cell.
module spike_key_matcher (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [2:0]   cfg_wr_data,   // entries_in_use
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [1:0]   s_tuser,       // kind
    // packet_time, packet_key, entry_select, match_key, match_mask,
    // core_shift, core_field_mask, colour_bits, per_core, list_limit; pad to 216
    input  logic [215:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [2:0]   m_tuser,       // status
    // entry_hit, spike_delay, source_id, slot, received_total,
    // delay_lost_total, overflow_lost_total, stored_count; pad to 176
    output logic [175:0] m_tdata
);
    import skm_pkg::*;

    state_t       state_reg, state_next;
    logic [2:0]   nuse_reg;
    token_t       head;
    token_t       row [NumEntries+1];
    token_t       fin_reg;
    logic [31:0]  prod_reg;
    logic [2:0]   st_reg;
    logic         adv;
    logic         st_row_valid;
    // last delay-lost entry counters, captured as the item passes that cell
    logic [31:0]  lr_reg, ld_reg, lo_reg;
    logic [6:0]   lc_reg;
    logic [2:0]   status;
    logic [31:0]  src;
    logic [StoreAw-1:0] waddr;
    logic [62:0]  store_mem [StoreDepth];

    always_comb begin
        head         = '0;
        head.valid   = s_tvalid && s_tready;
        head.kind    = s_tuser;
        head.ptime   = s_tdata[31:0];
        head.pkey    = s_tdata[63:32];
        head.sel     = s_tdata[65:64];
        head.mkey    = s_tdata[97:66];
        head.mmask   = s_tdata[129:98];
        head.cshift  = s_tdata[134:130];
        head.cmask   = s_tdata[166:135];
        head.cbits   = s_tdata[171:167];
        head.percore = s_tdata[203:172];
        head.limit   = s_tdata[210:204];
        head.nuse    = (nuse_reg > 3'(NumEntries)) ? 3'(NumEntries) : nuse_reg;
    end

    assign row[0] = head;
    assign adv = 1'b1;

    for (genvar g = 0; g < NumEntries; g++) begin : g_row
        skm_cell u_cell (
            .aclk(aclk), .aresetn(aresetn), .cell_id(EntryW'(g)), .adv(adv),
            .tok_in(row[g]), .tok_out(row[g+1])
        );
    end

    assign st_row_valid = row[NumEntries].valid;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (s_tvalid) state_next = S_SCAN;
            S_SCAN: if (st_row_valid) state_next = S_PROD;
            S_PROD: state_next = S_OUT;
            S_OUT:  if (m_tready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_tready = (state_reg == S_IDLE);
        m_tvalid = (state_reg == S_OUT);
    end

    always_comb begin
        token_t t;
        t = row[NumEntries];
        if (t.kind == KIND_WRITE || t.kind == KIND_CLEAR) status = ST_TABLE;
        else if (t.kind != KIND_SPIKE) status = ST_NOMATCH;
        else if (t.hit) status = t.full ? ST_FULL : ST_STORED;
        else if (t.lost) status = ST_DELAY;
        else status = ST_NOMATCH;
    end

    assign src   = prod_reg + fin_reg.local_id;
    assign waddr = {fin_reg.hit_e[EntryW-1:0], fin_reg.slot};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            nuse_reg  <= '0;
            fin_reg   <= '0;
            st_reg    <= ST_NOMATCH;
            prod_reg  <= '0;
            lr_reg <= '0; ld_reg <= '0; lo_reg <= '0; lc_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) nuse_reg <= cfg_wr_data;
            if (state_reg == S_SCAN && st_row_valid) begin
                fin_reg <= row[NumEntries];
                st_reg  <= status;
            end
            if (state_reg == S_PROD) begin
                prod_reg <= 32'(fin_reg.core * fin_reg.percore_h);
            end
            for (int k = 0; k < NumEntries; k++) begin
                if (row[k+1].valid && row[k+1].lost &&
                    row[k+1].lost_e == 2'(k) && row[k+1].kind == KIND_SPIKE &&
                    !row[k+1].hit) begin
                    lr_reg <= row[k+1].rcv;
                    ld_reg <= row[k+1].dlost;
                    lo_reg <= row[k+1].olost;
                    lc_reg <= row[k+1].cnt;
                end
            end
        end
    end

    // spike list memory, written once per stored spike as its result leaves
    always_ff @(posedge aclk) begin
        if (state_reg == S_OUT && m_tready && st_reg == ST_STORED) begin
            store_mem[waddr] <= {src, fin_reg.delay};
        end
    end

    always_comb begin
        m_tuser = st_reg;
        m_tdata = '0;
        case (st_reg)
            ST_STORED, ST_FULL: begin
                m_tdata[1:0]     = fin_reg.hit_e;
                m_tdata[32:2]    = fin_reg.delay;
                m_tdata[64:33]   = src;
                m_tdata[70:65]   = (st_reg == ST_STORED) ? fin_reg.slot : '0;
                m_tdata[102:71]  = fin_reg.rcv;
                m_tdata[134:103] = fin_reg.dlost;
                m_tdata[166:135] = fin_reg.olost;
                m_tdata[173:167] = fin_reg.cnt;
            end
            ST_DELAY: begin
                m_tdata[1:0]     = fin_reg.lost_e;
                m_tdata[102:71]  = lr_reg;
                m_tdata[134:103] = ld_reg;
                m_tdata[166:135] = lo_reg;
                m_tdata[173:167] = lc_reg;
            end
            ST_TABLE: begin
                if (fin_reg.kind == KIND_WRITE) m_tdata[1:0] = fin_reg.sel;
            end
            default: m_tdata = '0;
        endcase
    end

`ifndef SYNTHESIS
    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid)) else $error("accept while result pending");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped");
    a_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == ST_STORED |-> m_tdata[173:167] != 7'd0)
        else $error("stored with empty list");
`endif
endmodule

@@ tb/tb.sv @@
// Self-checking bench for spike_key_matcher: random and directed table writes,
// spike packets and clears, checked against a behavioral predictor of the matcher.
// Depends on rtl/skm_pkg.sv and rtl/spike_key_matcher.sv (and rtl/skm_cell.sv through it).
`timescale 1ns / 100ps

module tb;
    import skm_pkg::*;

    typedef struct packed {
        logic [2:0]  status;
        logic [1:0]  entry_hit;
        logic [30:0] spike_delay;
        logic [31:0] source_id;
        logic [5:0]  slot;
        logic [31:0] received_total;
        logic [31:0] delay_lost_total;
        logic [31:0] overflow_lost_total;
        logic [6:0]  stored_count;
    } match_result_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] ptime;
        logic [31:0] pkey;
        logic [1:0]  sel;
        logic [31:0] mkey;
        logic [31:0] mmask;
        logic [4:0]  cshift;
        logic [31:0] cmask;
        logic [4:0]  cbits;
        logic [31:0] percore;
        logic [6:0]  limit;
    } packet_item_t;

    int mismatch_count = 0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    class matcher_scoreboard;
        logic [2:0]  in_use;
        logic [31:0] t_key[NumEntries], t_mask[NumEntries], t_cmask[NumEntries];
        logic [31:0] t_percore[NumEntries];
        logic [4:0]  t_shift[NumEntries], t_cbits[NumEntries];
        logic [6:0]  t_limit[NumEntries], n_stored[NumEntries];
        logic [31:0] n_rcv[NumEntries], n_dlost[NumEntries], n_olost[NumEntries];
        match_result_t pending[$];

        function new();
            in_use = '0;
            for (int e = 0; e < NumEntries; e++) begin
                t_key[e] = '0; t_mask[e] = '0; t_cmask[e] = '0; t_percore[e] = '0;
                t_shift[e] = '0; t_cbits[e] = '0; t_limit[e] = '0; n_stored[e] = '0;
                n_rcv[e] = '0; n_dlost[e] = '0; n_olost[e] = '0;
            end
        endfunction

        function void fill_entry(inout match_result_t r, input int e);
            r.entry_hit = e[1:0];
            r.received_total = n_rcv[e];
            r.delay_lost_total = n_dlost[e];
            r.overflow_lost_total = n_olost[e];
            r.stored_count = n_stored[e];
        endfunction

        function void note_item(input packet_item_t it);
            match_result_t r;
            int n, lost_e, lim;
            bit lost, done;
            logic [31:0] cm, dly, core, lmask, lid, src;
            r = '0;
            lost = 0; lost_e = 0; done = 0;
            if (it.kind == KIND_WRITE) begin
                r.status = ST_TABLE;
                t_key[it.sel] = it.mkey; t_mask[it.sel] = it.mmask;
                t_shift[it.sel] = it.cshift; t_cmask[it.sel] = it.cmask;
                t_cbits[it.sel] = it.cbits; t_percore[it.sel] = it.percore;
                t_limit[it.sel] = it.limit; n_stored[it.sel] = '0;
                n_rcv[it.sel] = '0; n_dlost[it.sel] = '0; n_olost[it.sel] = '0;
                fill_entry(r, int'(it.sel));
            end else if (it.kind == KIND_CLEAR) begin
                r.status = ST_TABLE;
                for (int e = 0; e < NumEntries; e++) n_stored[e] = '0;
            end else if (it.kind != KIND_SPIKE) begin
                r.status = ST_NOMATCH;
            end else begin
                n = (in_use > NumEntries) ? NumEntries : int'(in_use);
                for (int e = 0; e < n && !done; e++) begin
                    if ((it.pkey & t_mask[e]) == t_key[e]) begin
                        n_rcv[e]++;
                        cm = (32'd1 << t_cbits[e]) - 32'd1;
                        dly = (it.ptime & cm) - (it.pkey & cm);
                        if (dly > cm) begin
                            n_dlost[e]++;
                            lost = 1; lost_e = e;
                        end else begin
                            core = (it.pkey >> t_shift[e]) & t_cmask[e];
                            lmask = ~(t_mask[e] | (t_cmask[e] << t_shift[e]));
                            lid = (it.pkey & lmask) >> t_cbits[e];
                            src = core * t_percore[e] + lid;
                            lim = (t_limit[e] > MaxSpikes) ? MaxSpikes : int'(t_limit[e]);
                            r.spike_delay = dly[30:0];
                            r.source_id = src;
                            if (n_stored[e] >= lim) begin
                                n_olost[e]++;
                                r.status = ST_FULL;
                            end else begin
                                r.slot = n_stored[e][5:0];
                                n_stored[e]++;
                                r.status = ST_STORED;
                            end
                            fill_entry(r, e);
                            done = 1;
                        end
                    end
                end
                if (!done) begin
                    if (lost) begin
                        r.status = ST_DELAY;
                        fill_entry(r, lost_e);
                    end else r.status = ST_NOMATCH;
                end
            end
            pending.push_back(r);
        endfunction

        task check_result(input logic [2:0] st, input logic [175:0] d);
            match_result_t g, w;
            g.status = st;
            g.entry_hit = d[1:0];
            g.spike_delay = d[32:2];
            g.source_id = d[64:33];
            g.slot = d[70:65];
            g.received_total = d[102:71];
            g.delay_lost_total = d[134:103];
            g.overflow_lost_total = d[166:135];
            g.stored_count = d[173:167];
            if (pending.size() == 0) begin
                report_mismatch("unexpected result", 32'(g.status), 32'd0);
                return;
            end
            w = pending.pop_front();
            if (g.status !== w.status) report_mismatch("status", 32'(g.status),
                                                       32'(w.status));
            if (g.entry_hit !== w.entry_hit)
                report_mismatch("entry_hit", 32'(g.entry_hit), 32'(w.entry_hit));
            if (g.spike_delay !== w.spike_delay)
                report_mismatch("spike_delay", 32'(g.spike_delay), 32'(w.spike_delay));
            if (g.source_id !== w.source_id)
                report_mismatch("source_id", g.source_id, w.source_id);
            if (g.slot !== w.slot) report_mismatch("slot", 32'(g.slot), 32'(w.slot));
            if (g.received_total !== w.received_total)
                report_mismatch("received_total", g.received_total, w.received_total);
            if (g.delay_lost_total !== w.delay_lost_total)
                report_mismatch("delay_lost_total", g.delay_lost_total,
                                w.delay_lost_total);
            if (g.overflow_lost_total !== w.overflow_lost_total)
                report_mismatch("overflow_lost_total", g.overflow_lost_total,
                                w.overflow_lost_total);
            if (g.stored_count !== w.stored_count)
                report_mismatch("stored_count", 32'(g.stored_count),
                                32'(w.stored_count));
        endtask
    endclass

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         cfg_wr_en = 0;
    logic [2:0]   cfg_wr_data = '0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [1:0]   s_tuser = '0;
    logic [215:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [2:0]   m_tuser;
    logic [175:0] m_tdata;

    int send_idle_pct = 21;
    int recv_idle_pct = 76;
    matcher_scoreboard board = new();

    spike_key_matcher uut (.*);

    always begin
        #6 aclk = 1;
        #6 aclk = 0;
    end

    // receiver: stall at random, check on accepted results
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) board.check_result(m_tuser, m_tdata);
    end
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_item(input packet_item_t it);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) @(negedge aclk);
        s_tvalid <= 1;
        s_tuser <= it.kind;
        s_tdata <= {5'd0, it.limit, it.percore, it.cbits, it.cmask, it.cshift,
                    it.mmask, it.mkey, it.sel, it.pkey, it.ptime};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.note_item(it);
        @(negedge aclk);
        s_tvalid <= 0;
    endtask

    task automatic drain_results();
        while (board.pending.size() != 0) @(negedge aclk);
        repeat (10) @(negedge aclk);
    endtask

    task automatic set_in_use(input logic [2:0] v);
        drain_results();
        cfg_wr_en <= 1;
        cfg_wr_data <= v;
        @(negedge aclk);
        cfg_wr_en <= 0;
        board.in_use = v;
    endtask

    function automatic packet_item_t table_write(input logic [1:0] sel);
        packet_item_t it;
        it = '0;
        it.kind = KIND_WRITE;
        it.sel = sel;
        it.cbits = 5'($urandom_range(8));
        it.mmask = ~32'hff ^ ($urandom_range(1) ? 32'h0 : 32'hff00);
        it.mkey = {2'($urandom_range(3)), 30'd0} & it.mmask;
        it.cshift = 5'($urandom_range(31));
        it.cmask = $urandom;
        it.percore = $urandom;
        it.limit = ($urandom_range(9) == 0) ? 7'($urandom_range(127))
                                            : 7'($urandom_range(6));
        return it;
    endfunction

    // spike aimed at some table entry most of the time
    function automatic packet_item_t spike(input logic [31:0] base);
        packet_item_t it;
        it = '0;
        it.kind = KIND_SPIKE;
        it.ptime = $urandom;
        it.pkey = ($urandom_range(4) == 0) ? $urandom : (base | $urandom_range(16'hffff));
        it.mkey = $urandom; it.mmask = $urandom; it.cmask = $urandom;
        it.percore = $urandom; it.sel = 2'($urandom); it.limit = 7'($urandom);
        return it;
    endfunction

    initial begin
        packet_item_t it;
        int r;
        repeat (9) @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);

        // directed: spike into empty table, unknown kind, clear, extremes
        it = '0; it.kind = KIND_SPIKE; send_item(it);
        it = '1; it.kind = KIND_NONE; send_item(it);
        it = '1; it.kind = KIND_CLEAR; send_item(it);
        set_in_use(3'd7);
        it = '0; it.kind = KIND_WRITE; it.sel = 2'd0; it.limit = 7'd127;
        it.cbits = 5'd31; it.cmask = '1; it.percore = '1; it.cshift = 5'd31;
        send_item(it);
        it = '1; it.kind = KIND_WRITE; it.sel = 2'd3; it.mkey = '1; it.cbits = 5'd0;
        it.limit = 7'd1; send_item(it);
        it = '0; it.kind = KIND_WRITE; it.sel = 2'd1; it.limit = 7'd2; it.cbits = 5'd4;
        it.mmask = 32'hffff0000; it.mkey = 32'h12340000; send_item(it);
        it = '1; it.kind = KIND_SPIKE; send_item(it);
        send_item(it);
        it = '0; it.kind = KIND_SPIKE; it.pkey = 32'h12340005; it.ptime = 32'd3;
        send_item(it);                      // delay too large on entry 1
        it.ptime = 32'hffffffff; send_item(it);
        send_item(it); send_item(it);       // stored in entry 0, which matches any key
        it.pkey = '0; it.ptime = '1; send_item(it);
        it.pkey = '1; it.ptime = '0; send_item(it);
        it = '0; it.kind = KIND_CLEAR; send_item(it);

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 21 : (phase == 1) ? 76 : 0;
            recv_idle_pct = (phase == 0) ? 76 : (phase == 1) ? 21 : 0;
            for (int blk = 0; blk < 6; blk++) begin
                set_in_use(3'($urandom_range(7)));
                for (int e = 0; e < NumEntries; e++) send_item(table_write(2'(e)));
                for (int k = 0; k < 80; k++) begin
                    r = $urandom_range(99);
                    if (r < 3) begin
                        it = table_write(2'($urandom));
                    end else if (r < 6) begin
                        it = '0; it.kind = KIND_CLEAR; it.ptime = $urandom;
                    end else if (r < 8) begin
                        it = spike(32'd0); it.kind = KIND_NONE;
                    end else begin
                        it = spike({2'($urandom_range(3)), 30'd0});
                    end
                    send_item(it);
                    if (k == 40 && blk == 0) drain_results();
                end
            end
        end
        set_in_use(3'd0);
        it = spike(32'd0); send_item(it);
        set_in_use(3'd4);
        drain_results();
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("end of test: mismatches");
        $finish;
    end
endmodule
